FILE: hw/rtl/owt_pkg.sv
// Shared types, constants and angle helpers for the outline winding tracker.
`default_nettype none

package owt_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ANGLE_BITS     = 20;
    localparam int SUM_BITS       = 64;
    localparam int TOL_BITS       = 16;
    localparam int EPS_BITS       = 10;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam int FULL_TURN      = 368640;

    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(10);
    localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_RESTART = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_CIRCLE_ONTO  = 2'd1,
        ST_AFTER_CIRCLE = 2'd2,
        ST_DISJOINT     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_JOIN_TOL  = CFG_IDX_BITS'(0),
        REG_ANGLE_EPS = CFG_IDX_BITS'(1)
    } t_cfg_reg;

    typedef struct packed {
        t_status    status;
        logic       acc;
        logic       clr;
        logic       big;
        logic       ccw_small;
        logic       circ;
        logic [1:0] count;
    } t_seg_flags;

    function automatic logic f_is_line(input logic signed [ANGLE_BITS-1:0] ang,
                                       input logic [EPS_BITS-1:0] eps);
        logic signed [ANGLE_BITS+1:0] a;
        logic signed [ANGLE_BITS+1:0] e;
        a = (ANGLE_BITS+2)'(ang);
        e = $signed({{(ANGLE_BITS+2-EPS_BITS){1'b0}}, eps});
        return (a < e) && (a > -e);
    endfunction

    function automatic logic f_is_circle(input logic signed [ANGLE_BITS-1:0] ang,
                                         input logic [EPS_BITS-1:0] eps);
        logic signed [ANGLE_BITS+1:0] a;
        logic signed [ANGLE_BITS+1:0] m;
        logic signed [ANGLE_BITS+1:0] d;
        logic signed [ANGLE_BITS+1:0] e;
        a = (ANGLE_BITS+2)'(ang);
        m = a[ANGLE_BITS+1] ? -a : a;
        d = m - (ANGLE_BITS+2)'(FULL_TURN);
        e = $signed({{(ANGLE_BITS+2-EPS_BITS){1'b0}}, eps});
        return (d < e) && (d > -e);
    endfunction

    function automatic logic [ANGLE_BITS-1:0] f_mag(input logic signed [ANGLE_BITS-1:0] ang);
        return ang[ANGLE_BITS-1] ? ANGLE_BITS'(-ang) : ANGLE_BITS'(ang);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/owt_front.sv
// Input register, join check, outline state and winding rules for short outlines.
`default_nettype none

module owt_front
    import owt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [TOL_BITS-1:0]          i_join_tol,
    input  wire  [EPS_BITS-1:0]          i_angle_eps,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [1:0]                   i_mode,
    input  wire  signed [COORD_BITS-1:0] i_sx,
    input  wire  signed [COORD_BITS-1:0] i_sy,
    input  wire  signed [COORD_BITS-1:0] i_ex,
    input  wire  signed [COORD_BITS-1:0] i_ey,
    input  wire  signed [ANGLE_BITS-1:0] i_ang,
    output logic                         o_valid,
    input  wire                          i_ready,
    output t_seg_flags                   o_flags,
    output logic signed [2*COORD_BITS+1:0] o_prod,
    output logic signed [COORD_BITS-1:0] o_fsx,
    output logic signed [COORD_BITS-1:0] o_fsy,
    output logic signed [COORD_BITS-1:0] o_lex,
    output logic signed [COORD_BITS-1:0] o_ley
);

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * COORD_BITS + 2;
    localparam int D2W  = 2 * COORD_BITS + 1;
    localparam int CMPW = (D2W > 2 * TOL_BITS) ? D2W : 2 * TOL_BITS;

    logic                         r_a_valid;
    t_mode                        r_a_mode;
    logic signed [COORD_BITS-1:0] r_a_sx, r_a_sy, r_a_ex, r_a_ey;
    logic signed [ANGLE_BITS-1:0] r_a_ang;

    logic [1:0]                   r_held;
    logic signed [COORD_BITS-1:0] r_fsx, r_fsy, r_lex, r_ley;
    logic signed [ANGLE_BITS-1:0] r_fa, r_la;

    logic [1:0]                   n_held;
    logic signed [COORD_BITS-1:0] n_fsx, n_fsy, n_lex, n_ley;
    logic signed [ANGLE_BITS-1:0] n_fa, n_la;

    logic                         r_b_valid;
    t_seg_flags                   r_b_flags;
    logic signed [PW-1:0]         r_b_prod;
    logic signed [COORD_BITS-1:0] r_b_fsx, r_b_fsy, r_b_lex, r_b_ley;

    logic                         en_b, move_ab;
    logic signed [DW-1:0]         dx, dy, ddx, ssy, ax, ay;
    logic [COORD_BITS-1:0]        ux, uy;
    logic [2*COORD_BITS-1:0]      ux2, uy2;
    logic [D2W-1:0]               d2;
    logic [2*TOL_BITS-1:0]        tol2;
    logic                         far;
    logic signed [PW-1:0]         prod;
    logic                         clr, add, acc, first_new, fa_circ, l1, l2;
    logic [1:0]                   base_held;
    t_status                      status;
    t_seg_flags                   flags;

    assign en_b    = !r_b_valid || i_ready;
    assign move_ab = r_a_valid && en_b;
    assign o_ready = !r_a_valid || en_b;

    // join distance against the previous end
    assign dx   = DW'(r_a_sx) - DW'(r_lex);
    assign dy   = DW'(r_a_sy) - DW'(r_ley);
    assign ax   = dx[DW-1] ? -dx : dx;
    assign ay   = dy[DW-1] ? -dy : dy;
    assign ux   = ax[COORD_BITS-1:0];
    assign uy   = ay[COORD_BITS-1:0];
    assign ux2  = ux * ux;
    assign uy2  = uy * uy;
    assign d2   = D2W'(ux2) + D2W'(uy2);
    assign tol2 = i_join_tol * i_join_tol;
    assign far  = CMPW'(d2) > CMPW'(tol2);

    // shoelace term of the segment itself
    assign ddx  = DW'(r_a_ex) - DW'(r_a_sx);
    assign ssy  = DW'(r_a_ey) + DW'(r_a_sy);
    assign prod = ddx * ssy;

    always_comb begin
        clr       = (r_a_mode == MODE_RESTART) || (r_a_mode == MODE_CLEAR);
        add       = (r_a_mode == MODE_APPEND) || (r_a_mode == MODE_RESTART);
        base_held = clr ? 2'd0 : r_held;
        status    = ST_OK;
        if (add && base_held != 2'd0) begin
            if (f_is_circle(r_a_ang, i_angle_eps)) begin
                status = ST_CIRCLE_ONTO;
            end else if (f_is_circle(r_la, i_angle_eps)) begin
                status = ST_AFTER_CIRCLE;
            end else if (far) begin
                status = ST_DISJOINT;
            end
        end
        acc       = add && (status == ST_OK);
        first_new = acc && (base_held == 2'd0);
        if (acc) begin
            n_held = (base_held == 2'd3) ? 2'd3 : base_held + 2'd1;
        end else begin
            n_held = base_held;
        end
        n_fsx = first_new ? r_a_sx  : r_fsx;
        n_fsy = first_new ? r_a_sy  : r_fsy;
        n_fa  = first_new ? r_a_ang : r_fa;
        n_lex = acc ? r_a_ex  : r_lex;
        n_ley = acc ? r_a_ey  : r_ley;
        n_la  = acc ? r_a_ang : r_la;

        fa_circ = f_is_circle(n_fa, i_angle_eps);
        l1      = f_is_line(n_fa, i_angle_eps);
        l2      = f_is_line(n_la, i_angle_eps);

        flags.status = status;
        flags.acc    = acc;
        flags.clr    = clr;
        flags.big    = (n_held == 2'd3);
        flags.circ   = (n_held != 2'd0) && fa_circ;
        flags.count  = n_held;
        case (n_held)
            2'd1: flags.ccw_small = fa_circ;
            2'd2: begin
                if (!l1 && !l2) begin
                    flags.ccw_small = (f_mag(n_fa) >= f_mag(n_la)) ? !n_fa[ANGLE_BITS-1]
                                                                   : !n_la[ANGLE_BITS-1];
                end else if (!l1) begin
                    flags.ccw_small = !n_fa[ANGLE_BITS-1];
                end else if (!l2) begin
                    flags.ccw_small = !n_la[ANGLE_BITS-1];
                end else begin
                    flags.ccw_small = 1'b0;
                end
            end
            default: flags.ccw_small = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_held    <= 2'd0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (move_ab) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_mode <= t_mode'(i_mode);
            r_a_sx   <= i_sx;
            r_a_sy   <= i_sy;
            r_a_ex   <= i_ex;
            r_a_ey   <= i_ey;
            r_a_ang  <= i_ang;
        end
        if (move_ab) begin
            r_fsx     <= n_fsx;
            r_fsy     <= n_fsy;
            r_fa      <= n_fa;
            r_lex     <= n_lex;
            r_ley     <= n_ley;
            r_la      <= n_la;
            r_b_flags <= flags;
            r_b_prod  <= prod;
            r_b_fsx   <= n_fsx;
            r_b_fsy   <= n_fsy;
            r_b_lex   <= n_lex;
            r_b_ley   <= n_ley;
        end
    end

    assign o_valid = r_b_valid;
    assign o_flags = r_b_flags;
    assign o_prod  = r_b_prod;
    assign o_fsx   = r_b_fsx;
    assign o_fsy   = r_b_fsy;
    assign o_lex   = r_b_lex;
    assign o_ley   = r_b_ley;

endmodule

`default_nettype wire

FILE: hw/rtl/owt_accum.sv
// Saturating shoelace accumulator and closing-term multiply.
`default_nettype none

module owt_accum
    import owt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  t_seg_flags               i_flags,
    input  wire  signed [2*COORD_BITS+1:0] i_prod,
    input  wire  signed [COORD_BITS-1:0]   i_fsx,
    input  wire  signed [COORD_BITS-1:0]   i_fsy,
    input  wire  signed [COORD_BITS-1:0]   i_lex,
    input  wire  signed [COORD_BITS-1:0]   i_ley,
    output logic                           o_valid,
    input  wire                            i_ready,
    output t_seg_flags                     o_flags,
    output logic signed [2*COORD_BITS+1:0] o_close,
    output logic signed [SUM_BITS-1:0]     o_sum
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic                       r_c_valid;
    t_seg_flags                 r_c_flags;
    logic signed [PW-1:0]       r_c_close;
    logic signed [SUM_BITS-1:0] r_sum, n_sum;

    logic                       en_c, move_bc;
    logic signed [SUM_BITS-1:0] base, term;
    logic signed [SUM_BITS:0]   wide;
    logic signed [DW-1:0]       cdx, csy;
    logic signed [PW-1:0]       close_t;

    assign en_c    = !r_c_valid || i_ready;
    assign move_bc = i_valid && en_c;
    assign o_ready = en_c;

    assign cdx     = DW'(i_fsx) - DW'(i_lex);
    assign csy     = DW'(i_fsy) + DW'(i_ley);
    assign close_t = cdx * csy;

    always_comb begin
        base = i_flags.clr ? '0 : r_sum;
        term = i_flags.acc ? SUM_BITS'(i_prod) : '0;
        wide = (SUM_BITS+1)'(base) + (SUM_BITS+1)'(term);
        if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
            n_sum = wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = wide[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_sum     <= '0;
        end else begin
            if (en_c) begin
                r_c_valid <= i_valid;
            end
            if (move_bc) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_bc) begin
            r_c_flags <= i_flags;
            r_c_close <= close_t;
        end
    end

    assign o_valid = r_c_valid;
    assign o_flags = r_c_flags;
    assign o_close = r_c_close;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

FILE: hw/rtl/owt_out.sv
// Closed-outline winding decision and result register.
`default_nettype none

module owt_out
    import owt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  t_seg_flags               i_flags,
    input  wire  signed [2*COORD_BITS+1:0] i_close,
    input  wire  signed [SUM_BITS-1:0]     i_sum,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [1:0]                     o_status,
    output logic                           o_is_ccw,
    output logic                           o_circle,
    output logic [1:0]                     o_count
);

    logic                     r_o_valid;
    logic [1:0]               r_o_status;
    logic                     r_o_ccw;
    logic                     r_o_circle;
    logic [1:0]               r_o_count;

    logic                     en_o;
    logic signed [SUM_BITS:0] closed;
    logic                     ccw;

    assign en_o    = !r_o_valid || i_ready;
    assign o_ready = en_o;

    // saturation keeps the sign, so the exact sum decides
    assign closed = (SUM_BITS+1)'(i_sum) + (SUM_BITS+1)'(i_close);
    assign ccw    = i_flags.big ? (closed[SUM_BITS] || (closed == '0)) : i_flags.ccw_small;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o && i_valid) begin
            r_o_status <= i_flags.status;
            r_o_ccw    <= ccw;
            r_o_circle <= i_flags.circ;
            r_o_count  <= i_flags.count;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_is_ccw = r_o_ccw;
    assign o_circle = r_o_circle;
    assign o_count  = r_o_count;

endmodule

`default_nettype wire

FILE: hw/rtl/outline_winding_tracker.sv
// Top level of the outline winding tracker: configuration registers and stage wiring.
//
//  channel | direction | handshake              | word
//  in      | sink      | i_in_valid/o_in_ready   | mode, segment start, end, arc angle
//  out     | source    | o_out_valid/i_out_ready | status, winding, circle flag, count
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | register index, data
//
// One word per cycle sustained unless the output stalls; a word passes the input, front output,
// accumulator and result registers in turn. The loop that sets the rate is the join check and
// outline state update of the front stage, one segment a cycle. Four registered stages, each
// stalls only when full and blocked downstream. Synchronous reset empties the pipe, clears the
// outline and loads the default tolerance and epsilon. Configuration writes are taken every cycle.
`default_nettype none

module outline_winding_tracker
    import owt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [1:0]                   i_mode,
    input  wire  signed [COORD_BITS-1:0] i_seg_start_x,
    input  wire  signed [COORD_BITS-1:0] i_seg_start_y,
    input  wire  signed [COORD_BITS-1:0] i_seg_end_x,
    input  wire  signed [COORD_BITS-1:0] i_seg_end_y,
    input  wire  signed [ANGLE_BITS-1:0] i_arc_angle,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [1:0]                   o_status,
    output logic                         o_is_ccw,
    output logic                         o_outline_is_circle,
    output logic [1:0]                   o_segment_count,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire  [CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic [TOL_BITS-1:0]          r_join_tol;
    logic [EPS_BITS-1:0]          r_angle_eps;

    logic                         b_valid, b_ready;
    t_seg_flags                   b_flags;
    logic signed [PW-1:0]         b_prod;
    logic signed [COORD_BITS-1:0] b_fsx, b_fsy, b_lex, b_ley;

    logic                         c_valid, c_ready;
    t_seg_flags                   c_flags;
    logic signed [PW-1:0]         c_close;
    logic signed [SUM_BITS-1:0]   c_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_join_tol  <= TOL_RESET;
            r_angle_eps <= EPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_JOIN_TOL:  r_join_tol  <= i_cfg_data[TOL_BITS-1:0];
                REG_ANGLE_EPS: r_angle_eps <= i_cfg_data[EPS_BITS-1:0];
                default: ;
            endcase
        end
    end

    owt_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_join_tol  (r_join_tol),
        .i_angle_eps (r_angle_eps),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_mode      (i_mode),
        .i_sx        (i_seg_start_x),
        .i_sy        (i_seg_start_y),
        .i_ex        (i_seg_end_x),
        .i_ey        (i_seg_end_y),
        .i_ang       (i_arc_angle),
        .o_valid     (b_valid),
        .i_ready     (b_ready),
        .o_flags     (b_flags),
        .o_prod      (b_prod),
        .o_fsx       (b_fsx),
        .o_fsy       (b_fsy),
        .o_lex       (b_lex),
        .o_ley       (b_ley)
    );

    owt_accum #(
        .COORD_BITS(COORD_BITS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .o_ready (b_ready),
        .i_flags (b_flags),
        .i_prod  (b_prod),
        .i_fsx   (b_fsx),
        .i_fsy   (b_fsy),
        .i_lex   (b_lex),
        .i_ley   (b_ley),
        .o_valid (c_valid),
        .i_ready (c_ready),
        .o_flags (c_flags),
        .o_close (c_close),
        .o_sum   (c_sum)
    );

    owt_out #(
        .COORD_BITS(COORD_BITS)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid),
        .o_ready  (c_ready),
        .i_flags  (c_flags),
        .i_close  (c_close),
        .i_sum    (c_sum),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_status (o_status),
        .o_is_ccw (o_is_ccw),
        .o_circle (o_outline_is_circle),
        .o_count  (o_segment_count)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/owt_checker.sv
// Port-level assertions for the outline winding tracker, bound to the top level.
`default_nettype none

module owt_checker
    import owt_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [1:0] o_status,
    input wire       o_is_ccw,
    input wire       o_outline_is_circle,
    input wire [1:0] o_segment_count
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_is_ccw) && $stable(o_segment_count))
        else $error("stalled result word changed");

    a_empty_outline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_segment_count == 2'd0 |-> !o_is_ccw && !o_outline_is_circle)
        else $error("empty outline reports winding or circle");

    a_single_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_segment_count == 2'd1 |-> o_is_ccw == o_outline_is_circle)
        else $error("single-segment winding disagrees with circle flag");

    a_reject_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_segment_count != 2'd0)
        else $error("segment rejected from an empty outline");

endmodule

bind outline_winding_tracker owt_checker u_owt_checker (.*);

`default_nettype wire

FILE: tb/outline_winding_tracker_test.sv
// Self-checking testbench for the outline winding tracker: random-stall handshakes, shoelace predictor.
module outline_winding_tracker_test;
    import owt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS_DEF - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int PHASES = 7;
    localparam int PHASE_WORDS = 130;
    localparam int unsigned TOL_PLAN [PHASES] = '{10, 0, 65535, 0, 1, 65535, 300};
    localparam int unsigned EPS_PLAN [PHASES] = '{1, 0, 1023, 0, 1023, 0, 40};

    typedef struct {
        t_mode                              mode;
        logic signed [COORD_BITS_DEF-1:0]   sx;
        logic signed [COORD_BITS_DEF-1:0]   sy;
        logic signed [COORD_BITS_DEF-1:0]   ex;
        logic signed [COORD_BITS_DEF-1:0]   ey;
        logic signed [ANGLE_BITS-1:0]       ang;
    } t_segment;

    typedef struct {
        t_status    status;
        logic       ccw;
        logic       circle;
        logic [1:0] count;
    } t_report;

    logic i_clk;
    logic rst_n = 1'b0;

    logic                               in_valid = 1'b0;
    logic                               o_in_ready;
    t_mode                              seg_mode = MODE_APPEND;
    logic signed [COORD_BITS_DEF-1:0]   seg_sx = '0;
    logic signed [COORD_BITS_DEF-1:0]   seg_sy = '0;
    logic signed [COORD_BITS_DEF-1:0]   seg_ex = '0;
    logic signed [COORD_BITS_DEF-1:0]   seg_ey = '0;
    logic signed [ANGLE_BITS-1:0]       seg_ang = '0;
    logic                               o_out_valid;
    logic                               out_ready = 1'b0;
    logic [1:0]                         o_status;
    logic                               o_is_ccw;
    logic                               o_outline_is_circle;
    logic [1:0]                         o_segment_count;
    logic                               cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]            cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]           cfg_data = '0;

    outline_winding_tracker dut (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_mode              (seg_mode),
        .i_seg_start_x       (seg_sx),
        .i_seg_start_y       (seg_sy),
        .i_seg_end_x         (seg_ex),
        .i_seg_end_y         (seg_ey),
        .i_arc_angle         (seg_ang),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_status            (o_status),
        .o_is_ccw            (o_is_ccw),
        .o_outline_is_circle (o_outline_is_circle),
        .o_segment_count     (o_segment_count),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    t_segment segment_queue [$];
    t_report  expected_reports [$];
    t_segment held_seg;
    int       send_gap = 0;
    bit       send_burst = 0;
    int       recv_stall = 0;
    bit       recv_burst = 0;
    int       mismatches = 0;
    int       results_seen = 0;

    // register copies
    longint join_tol = 10;
    longint angle_eps = 1;

    // outline as predicted
    int     ol_count = 0;
    longint ol_sum = 0;
    longint ol_first_x = 0;
    longint ol_first_y = 0;
    longint ol_first_ang = 0;
    longint ol_last_x = 0;
    longint ol_last_y = 0;
    longint ol_last_ang = 0;

    // stimulus chain: end point that the next joined segment starts from
    longint chain_x = 0;
    longint chain_y = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit line_angle(longint a);
        return a < angle_eps && a > -angle_eps;
    endfunction

    function automatic bit circle_angle(longint a);
        longint d;
        d = (a < 0 ? -a : a) - longint'(FULL_TURN);
        return d < angle_eps && d > -angle_eps;
    endfunction

    function automatic longint sum_sat(longint a, longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic bit outline_ccw();
        longint m1;
        longint m2;
        longint closing;
        if (ol_count == 0)
            return 1'b0;
        if (ol_count == 1)
            return circle_angle(ol_first_ang);
        if (ol_count == 2) begin
            if (!line_angle(ol_first_ang) && !line_angle(ol_last_ang)) begin
                m1 = ol_first_ang < 0 ? -ol_first_ang : ol_first_ang;
                m2 = ol_last_ang < 0 ? -ol_last_ang : ol_last_ang;
                return m1 >= m2 ? ol_first_ang >= 0 : ol_last_ang >= 0;
            end
            if (!line_angle(ol_first_ang))
                return ol_first_ang >= 0;
            if (!line_angle(ol_last_ang))
                return ol_last_ang >= 0;
            return 1'b0;
        end
        closing = (ol_first_x - ol_last_x) * (ol_first_y + ol_last_y);
        return sum_sat(ol_sum, closing) <= 0;
    endfunction

    function automatic void clear_outline();
        ol_count = 0;
        ol_sum = 0;
        ol_first_x = 0;
        ol_first_y = 0;
        ol_first_ang = 0;
        ol_last_x = 0;
        ol_last_y = 0;
        ol_last_ang = 0;
    endfunction

    function automatic t_report trace_outline(t_segment s);
        t_report r;
        longint sx;
        longint sy;
        longint ex;
        longint ey;
        longint ang;
        longint dx;
        longint dy;
        sx = s.sx;
        sy = s.sy;
        ex = s.ex;
        ey = s.ey;
        ang = s.ang;
        r.status = ST_OK;
        if (s.mode == MODE_RESTART || s.mode == MODE_CLEAR)
            clear_outline();
        if (s.mode == MODE_APPEND || s.mode == MODE_RESTART) begin
            if (ol_count != 0) begin
                if (circle_angle(ang)) begin
                    r.status = ST_CIRCLE_ONTO;
                end else if (circle_angle(ol_last_ang)) begin
                    r.status = ST_AFTER_CIRCLE;
                end else begin
                    dx = sx - ol_last_x;
                    dy = sy - ol_last_y;
                    if (dx * dx + dy * dy > join_tol * join_tol)
                        r.status = ST_DISJOINT;
                end
            end
            if (r.status == ST_OK) begin
                if (ol_count == 0) begin
                    ol_first_x = sx;
                    ol_first_y = sy;
                    ol_first_ang = ang;
                end
                ol_last_x = ex;
                ol_last_y = ey;
                ol_last_ang = ang;
                ol_sum = sum_sat(ol_sum, (ex - sx) * (ey + sy));
                if (ol_count < 3)
                    ol_count++;
            end
        end
        r.ccw = outline_ccw();
        r.circle = ol_count != 0 && circle_angle(ol_first_ang);
        r.count = 2'(ol_count);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: result %0d: %s", $realtime, results_seen, what);
    endtask

    task automatic queue_segment(t_mode m, longint sx, longint sy, longint ex, longint ey,
                                 longint ang);
        t_segment s;
        s.mode = m;
        s.sx = COORD_BITS_DEF'(sx);
        s.sy = COORD_BITS_DEF'(sy);
        s.ex = COORD_BITS_DEF'(ex);
        s.ey = COORD_BITS_DEF'(ey);
        s.ang = ANGLE_BITS'(ang);
        segment_queue = {segment_queue, s};
    endtask

    function automatic longint pick_coord();
        int unsigned r;
        logic signed [COORD_BITS_DEF-1:0] c;
        r = $urandom_range(0, 9);
        c = COORD_BITS_DEF'($urandom);
        if (r < 6)
            return c;
        if (r < 9)
            return longint'(int'($urandom_range(0, 8191))) - 4096;
        return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // lines, circles, arcs, and angles just past each threshold
    function automatic longint pick_angle(bit want_circle);
        longint a;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (want_circle)
            a = longint'(FULL_TURN)
                - (angle_eps > 0 ? longint'(int'($urandom_range(0, angle_eps - 1))) : 0);
        else if (r < 4)
            a = angle_eps > 0
                ? longint'(int'($urandom_range(0, 2 * angle_eps - 2))) - (angle_eps - 1) : 0;
        else if (r < 5)
            a = angle_eps;
        else if (r < 6)
            a = longint'(FULL_TURN) - angle_eps;
        else
            a = longint'(int'($urandom_range(0, 2 * FULL_TURN))) - FULL_TURN;
        return $urandom_range(0, 1) ? -a : a;
    endfunction

    task automatic queue_random_segment();
        int unsigned r;
        int unsigned j;
        longint k;
        longint dx;
        longint dy;
        longint ex;
        longint ey;
        r = $urandom_range(0, 99);
        ex = pick_coord();
        ey = pick_coord();
        if (r < 8) begin
            queue_segment(t_mode'($urandom_range(0, 3)), pick_coord(), pick_coord(), ex, ey,
                          pick_angle($urandom_range(0, 9) == 0));
        end else if (r < 12) begin
            queue_segment(MODE_CLEAR, pick_coord(), pick_coord(), ex, ey, pick_angle(0));
        end else if (r < 27) begin
            queue_segment(MODE_RESTART, pick_coord(), pick_coord(), ex, ey,
                          pick_angle($urandom_range(0, 5) == 0));
            chain_x = ex;
            chain_y = ey;
        end else begin
            j = $urandom_range(0, 19);
            if (j < 2) begin
                // on the tolerance circle, or one unit outside it
                dx = join_tol;
                dy = j;
            end else begin
                k = join_tol * 7 / 10;
                dx = longint'(int'($urandom_range(0, 2 * k))) - k;
                dy = longint'(int'($urandom_range(0, 2 * k))) - k;
            end
            if ($urandom_range(0, 1))
                dx = -dx;
            if ($urandom_range(0, 1))
                dy = -dy;
            if ($urandom_range(0, 1)) begin
                k = dx;
                dx = dy;
                dy = k;
            end
            queue_segment(MODE_APPEND, clamp_coord(chain_x + dx), clamp_coord(chain_y + dy),
                          ex, ey, pick_angle($urandom_range(0, 24) == 0));
            if (j != 1) begin
                chain_x = ex;
                chain_y = ey;
            end
        end
    endtask

    task automatic queue_directed();
        queue_segment(MODE_RESTART, COORD_MIN, COORD_MIN, COORD_MAX - 20, COORD_MAX, 0);
        queue_segment(MODE_APPEND, COORD_MAX - 10, COORD_MAX, COORD_MAX, COORD_MIN, 92160);
        queue_segment(MODE_APPEND, COORD_MAX, COORD_MIN + 11, 0, 0, 0);
        queue_segment(MODE_APPEND, COORD_MAX - 6, COORD_MIN + 8, COORD_MIN, 0, -92160);
        queue_segment(MODE_APPEND, COORD_MIN, 0, COORD_MIN, 0, FULL_TURN);
        queue_segment(MODE_APPEND, COORD_MIN, 0, COORD_MIN, COORD_MAX, 1);
        queue_segment(MODE_APPEND, COORD_MIN + 7, COORD_MAX - 8, 0, 0, 0);
        queue_segment(MODE_CLEAR, 0, 0, 0, 0, 0);
        queue_segment(MODE_APPEND, 100, 100, 100, 100, -FULL_TURN);
        queue_segment(MODE_APPEND, 100, 100, 200, 200, 0);
        queue_segment(MODE_APPEND, 100, 100, 300, 300, FULL_TURN);
        queue_segment(MODE_NOP, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, -FULL_TURN);
        queue_segment(MODE_RESTART, 0, 0, 1000, 0, FULL_TURN - 1);
        queue_segment(MODE_APPEND, 1000, 0, 0, 0, -(FULL_TURN - 1));
        queue_segment(MODE_RESTART, 5, 5, 6, 6, -100);
        queue_segment(MODE_APPEND, 6, 6, 7, 7, 200);
        queue_segment(MODE_RESTART, 0, 0, 1000, 0, 0);
        queue_segment(MODE_APPEND, 1000, 0, 1000, 1000, 0);
        queue_segment(MODE_APPEND, 1000, 1000, 0, 1000, 0);
        queue_segment(MODE_APPEND, 0, 1000, 0, 0, 0);
        queue_segment(MODE_RESTART, 0, 0, 0, 1000, -1);
        queue_segment(MODE_APPEND, 0, 1000, 1000, 1000, 0);
        queue_segment(MODE_RESTART, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                      -(FULL_TURN - 1));
        queue_segment(MODE_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, FULL_TURN);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (segment_queue.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic write_register(t_cfg_reg idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_JOIN_TOL:  join_tol = data;
            REG_ANGLE_EPS: angle_eps = data[EPS_BITS-1:0];
            default: ;
        endcase
    endtask

    // sender
    always @(posedge i_clk) begin
        t_segment next_seg;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && o_in_ready)
                expected_reports = {expected_reports, trace_outline(held_seg)};
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (segment_queue.size() != 0) begin
                    next_seg = segment_queue.pop_front();
                    held_seg = next_seg;
                    in_valid <= 1'b1;
                    seg_mode <= next_seg.mode;
                    seg_sx <= next_seg.sx;
                    seg_sy <= next_seg.sy;
                    seg_ex <= next_seg.ex;
                    seg_ey <= next_seg.ey;
                    seg_ang <= next_seg.ang;
                    if ($urandom_range(0, 63) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 15);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_report want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (expected_reports.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    want = expected_reports.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  o_status, want.status));
                    if (o_is_ccw !== want.ccw)
                        report_mismatch($sformatf("is_ccw got %0d want %0d",
                                                  o_is_ccw, want.ccw));
                    if (o_outline_is_circle !== want.circle)
                        report_mismatch($sformatf("outline_is_circle got %0d want %0d",
                                                  o_outline_is_circle, want.circle));
                    if (o_segment_count !== want.count)
                        report_mismatch($sformatf("segment_count got %0d want %0d",
                                                  o_segment_count, want.count));
                end
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned tol;
        int unsigned eps;
        logic [CFG_DATA_BITS-1:0] cfg_word;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);
        queue_directed();
        wait_drained();
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                tol = TOL_PLAN[p];
                eps = EPS_PLAN[p];
                if (p == 3) begin
                    tol = $urandom_range(0, 65535);
                    eps = $urandom_range(0, 1023);
                end
                write_register(REG_JOIN_TOL, CFG_DATA_BITS'(tol));
                cfg_word = CFG_DATA_BITS'($urandom);
                cfg_word[EPS_BITS-1:0] = EPS_BITS'(eps);
                write_register(REG_ANGLE_EPS, cfg_word);
                @(negedge i_clk);
            end
            repeat (PHASE_WORDS) queue_random_segment();
            wait_drained();
        end
        repeat (10) @(posedge i_clk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_reports.size()));
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule
